@@ rtl/core/atilt_pkg.sv @@
package atilt_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int SUM_W      = 32;
    localparam int ROOT_W     = 32;
    localparam int REM_W      = 33;
    localparam int CD_W       = 36;
    localparam int ANG_W      = 28;
    localparam int FRAC_W     = 16;
    localparam int RES_W      = 10;
    localparam int OUT_W      = 11;
    localparam int TABLE_LEN  = 24;

    localparam logic [RES_W-1:0]        FULL_SCALE = 10'd900;
    localparam logic signed [ANG_W-1:0] Z_MAX      = 28'sd58982400;
    localparam logic signed [ANG_W-1:0] Z_HALF     = 28'sd32768;

    localparam logic [1:0] AXIS_X    = 2'd0;
    localparam logic [1:0] AXIS_Y    = 2'd1;
    localparam logic [1:0] AXIS_Z    = 2'd2;

    typedef struct packed {
        logic                forced;
        logic                neg;
        logic [SAMPLE_W-1:0] mag;
    } side_t;

    typedef struct packed {
        logic [SUM_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sq_t;

    typedef struct packed {
        logic signed [CD_W-1:0]  x;
        logic signed [CD_W-1:0]  y;
        logic signed [ANG_W-1:0] z;
    } cd_t;

    // atan(2^-i) in tenths of a degree, 16 fraction bits
    function automatic logic signed [ANG_W-1:0] atan_step(input int i);
        logic signed [ANG_W-1:0] t;
        case (i)
            0:       t = 28'sd29491200;
            1:       t = 28'sd17409672;
            2:       t = 28'sd9198793;
            3:       t = 28'sd4669451;
            4:       t = 28'sd2343786;
            5:       t = 28'sd1173036;
            6:       t = 28'sd586661;
            7:       t = 28'sd293348;
            8:       t = 28'sd146676;
            9:       t = 28'sd73339;
            10:      t = 28'sd36669;
            11:      t = 28'sd18335;
            12:      t = 28'sd9167;
            13:      t = 28'sd4584;
            14:      t = 28'sd2292;
            15:      t = 28'sd1146;
            16:      t = 28'sd573;
            17:      t = 28'sd286;
            18:      t = 28'sd143;
            19:      t = 28'sd72;
            20:      t = 28'sd36;
            21:      t = 28'sd18;
            22:      t = 28'sd9;
            23:      t = 28'sd4;
            default: t = 28'sd0;
        endcase
        return t;
    endfunction

endpackage

@@ rtl/core/atilt_front.sv @@
module atilt_front (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  logic                                  take,
    input  logic [1:0]                            kind,
    input  logic signed [atilt_pkg::SAMPLE_W-1:0] accel_x,
    input  logic signed [atilt_pkg::SAMPLE_W-1:0] accel_y,
    input  logic signed [atilt_pkg::SAMPLE_W-1:0] accel_z,
    output logic                                  valid_out,
    output atilt_pkg::side_t                      side_out,
    output atilt_pkg::sq_t                        sq_out
);

    logic signed [atilt_pkg::SAMPLE_W-1:0] a;
    logic signed [atilt_pkg::SAMPLE_W-1:0] b;
    logic signed [atilt_pkg::SAMPLE_W-1:0] c;
    logic                                  none;
    logic signed [2*atilt_pkg::SAMPLE_W-1:0] prod_b;
    logic signed [2*atilt_pkg::SAMPLE_W-1:0] prod_c;
    atilt_pkg::side_t                      side_a;

    logic                         valid_a_reg;
    atilt_pkg::side_t             side_a_reg;
    logic [atilt_pkg::SUM_W-1:0]  sqb_reg;
    logic [atilt_pkg::SUM_W-1:0]  sqc_reg;
    logic                         valid_b_reg;
    atilt_pkg::side_t             side_b_reg;
    logic [atilt_pkg::SUM_W-1:0]  sum_reg;
    logic [atilt_pkg::SUM_W-1:0]  sum_next;

    always_comb
    begin
        none = 1'b0;
        case (kind)
            atilt_pkg::AXIS_X:
            begin
                a = accel_x; b = accel_y; c = accel_z;
            end
            atilt_pkg::AXIS_Y:
            begin
                a = accel_y; b = accel_x; c = accel_z;
            end
            atilt_pkg::AXIS_Z:
            begin
                a = accel_z; b = accel_x; c = accel_y;
            end
            default:
            begin
                a = '0; b = '0; c = '0; none = 1'b1;
            end
        endcase
    end

    assign prod_b = b * b;
    assign prod_c = c * c;

    // a zero denominator or no axis bypasses the arctangent
    always_comb
    begin
        side_a.forced = none || (b == '0 && c == '0);
        side_a.neg    = a[atilt_pkg::SAMPLE_W-1];
        side_a.mag    = a[atilt_pkg::SAMPLE_W-1] ? $unsigned(-a) : $unsigned(a);
    end

    assign sum_next = sqb_reg + sqc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_a_reg <= take;
            valid_b_reg <= valid_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_a_reg <= side_a;
            sqb_reg    <= $unsigned(prod_b);
            sqc_reg    <= $unsigned(prod_c);
            side_b_reg <= side_a_reg;
            sum_reg    <= sum_next;
        end
    end

    assign valid_out   = valid_b_reg;
    assign side_out    = side_b_reg;
    assign sq_out.rad  = sum_reg;
    assign sq_out.rem  = '0;
    assign sq_out.root = '0;

endmodule

@@ rtl/core/atilt_sqrt_cell.sv @@
module atilt_sqrt_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             valid_in,
    input  atilt_pkg::side_t side_in,
    input  atilt_pkg::sq_t   sq_in,
    output logic             valid_out,
    output atilt_pkg::side_t side_out,
    output atilt_pkg::sq_t   sq_out
);

    logic [atilt_pkg::REM_W+1:0] rem_sh;
    logic [atilt_pkg::REM_W+1:0] trial;
    atilt_pkg::sq_t              sq_next;

    logic             valid_reg;
    atilt_pkg::side_t side_reg;
    atilt_pkg::sq_t   sq_reg;

    // bring down the next two radicand bits, try root bit one
    assign rem_sh = {sq_in.rem, sq_in.rad[atilt_pkg::SUM_W-1 -: 2]};
    assign trial  = {1'b0, sq_in.root, 2'b01};

    always_comb
    begin
        sq_next.rad = {sq_in.rad[atilt_pkg::SUM_W-3:0], 2'b00};
        if (rem_sh >= trial)
        begin
            sq_next.rem  = atilt_pkg::REM_W'(rem_sh - trial);
            sq_next.root = {sq_in.root[atilt_pkg::ROOT_W-2:0], 1'b1};
        end
        else
        begin
            sq_next.rem  = atilt_pkg::REM_W'(rem_sh);
            sq_next.root = {sq_in.root[atilt_pkg::ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg <= side_in;
            sq_reg   <= sq_next;
        end
    end

    assign valid_out = valid_reg;
    assign side_out  = side_reg;
    assign sq_out    = sq_reg;

endmodule

@@ rtl/core/atilt_cordic_cell.sv @@
module atilt_cordic_cell #(
    parameter int SHIFT = 0
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             valid_in,
    input  atilt_pkg::side_t side_in,
    input  atilt_pkg::cd_t   cd_in,
    output logic             valid_out,
    output atilt_pkg::side_t side_out,
    output atilt_pkg::cd_t   cd_out
);

    logic signed [atilt_pkg::CD_W-1:0]  dx;
    logic signed [atilt_pkg::CD_W-1:0]  dy;
    logic signed [atilt_pkg::ANG_W-1:0] step;
    atilt_pkg::cd_t                     cd_next;

    logic             valid_reg;
    atilt_pkg::side_t side_reg;
    atilt_pkg::cd_t   cd_reg;

    assign dx   = cd_in.y >>> SHIFT;
    assign dy   = cd_in.x >>> SHIFT;
    assign step = atilt_pkg::atan_step(SHIFT);

    // rotate toward y = 0, both updates from the old vector
    always_comb
    begin
        if (!cd_in.y[atilt_pkg::CD_W-1])
        begin
            cd_next.x = cd_in.x + dx;
            cd_next.y = cd_in.y - dy;
            cd_next.z = cd_in.z + step;
        end
        else
        begin
            cd_next.x = cd_in.x - dx;
            cd_next.y = cd_in.y + dy;
            cd_next.z = cd_in.z - step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg <= side_in;
            cd_reg   <= cd_next;
        end
    end

    assign valid_out = valid_reg;
    assign side_out  = side_reg;
    assign cd_out    = cd_reg;

endmodule

@@ rtl/core/accel_tilt_angle_unit.sv @@
// Tilt of one accelerometer axis against the plane of the other two, as
// atan(a / sqrt(b*b + c*c)) in tenths of a degree, rounded and within -900..900.
// The unit takes one transaction per cycle while in_stall is low and returns
// one result per transaction, in order. From input acceptance to out_valid a
// transaction passes a front end for axis selection, squaring and summing,
// 32 square-root cells (one root bit each), one CORDIC cell per step (at most
// 24), and the output register. A one-entry skid buffer behind the output
// register lets the chain keep moving after out_stall rises until a result
// lands in it; in_stall is high only while that buffer is occupied.
module accel_tilt_angle_unit #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [1:0]                            kind,
    input  logic signed [atilt_pkg::SAMPLE_W-1:0] accel_x,
    input  logic signed [atilt_pkg::SAMPLE_W-1:0] accel_y,
    input  logic signed [atilt_pkg::SAMPLE_W-1:0] accel_z,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [atilt_pkg::OUT_W-1:0]    angle_tenths
);

    localparam int NCELL = (CORDIC_STEPS > atilt_pkg::TABLE_LEN) ?
                           atilt_pkg::TABLE_LEN : CORDIC_STEPS;

    logic en;

    logic             sq_valid [atilt_pkg::ROOT_W+1];
    atilt_pkg::side_t sq_side  [atilt_pkg::ROOT_W+1];
    atilt_pkg::sq_t   sq_data  [atilt_pkg::ROOT_W+1];

    logic             cd_valid [NCELL+1];
    atilt_pkg::side_t cd_side  [NCELL+1];
    atilt_pkg::cd_t   cd_data  [NCELL+1];

    logic signed [atilt_pkg::ANG_W-1:0] z_clamp;
    logic signed [atilt_pkg::ANG_W-1:0] z_round;
    logic [atilt_pkg::RES_W-1:0]        res;
    logic signed [atilt_pkg::OUT_W-1:0] pipe_angle;
    logic                               pipe_valid;

    logic                               out_valid_reg;
    logic                               out_valid_next;
    logic signed [atilt_pkg::OUT_W-1:0] out_angle_reg;
    logic signed [atilt_pkg::OUT_W-1:0] out_angle_next;
    logic                               skid_full_reg;
    logic                               skid_full_next;
    logic signed [atilt_pkg::OUT_W-1:0] skid_angle_reg;
    logic signed [atilt_pkg::OUT_W-1:0] skid_angle_next;

    // the whole chain advances together unless the skid entry is occupied
    assign en = !skid_full_reg;

    atilt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .take      (in_valid),
        .kind      (kind),
        .accel_x   (accel_x),
        .accel_y   (accel_y),
        .accel_z   (accel_z),
        .valid_out (sq_valid[0]),
        .side_out  (sq_side[0]),
        .sq_out    (sq_data[0])
    );

    for (genvar g = 0; g < atilt_pkg::ROOT_W; g++)
    begin : g_sqrt
        atilt_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (sq_valid[g]),
            .side_in   (sq_side[g]),
            .sq_in     (sq_data[g]),
            .valid_out (sq_valid[g+1]),
            .side_out  (sq_side[g+1]),
            .sq_out    (sq_data[g+1])
        );
    end

    // start vector: x = root with 16 fraction bits, y = |a| with 16 fraction bits
    assign cd_valid[0]  = sq_valid[atilt_pkg::ROOT_W];
    assign cd_side[0]   = sq_side[atilt_pkg::ROOT_W];
    assign cd_data[0].x = $signed({{(atilt_pkg::CD_W-atilt_pkg::ROOT_W){1'b0}},
                                   sq_data[atilt_pkg::ROOT_W].root});
    assign cd_data[0].y = $signed({{(atilt_pkg::CD_W-atilt_pkg::SAMPLE_W
                                     -atilt_pkg::FRAC_W){1'b0}},
                                   sq_side[atilt_pkg::ROOT_W].mag,
                                   {atilt_pkg::FRAC_W{1'b0}}});
    assign cd_data[0].z = '0;

    for (genvar g = 0; g < NCELL; g++)
    begin : g_cordic
        atilt_cordic_cell #(
            .SHIFT (g)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (cd_valid[g]),
            .side_in   (cd_side[g]),
            .cd_in     (cd_data[g]),
            .valid_out (cd_valid[g+1]),
            .side_out  (cd_side[g+1]),
            .cd_out    (cd_data[g+1])
        );
    end

    // clamp to 0..90 degrees, round half up, apply the sign of a
    always_comb
    begin
        if (cd_data[NCELL].z < 0)
            z_clamp = '0;
        else if (cd_data[NCELL].z > atilt_pkg::Z_MAX)
            z_clamp = atilt_pkg::Z_MAX;
        else
            z_clamp = cd_data[NCELL].z;
        z_round = z_clamp + atilt_pkg::Z_HALF;

        if (cd_side[NCELL].forced)
            res = (cd_side[NCELL].mag != '0) ? atilt_pkg::FULL_SCALE : '0;
        else
            res = z_round[atilt_pkg::FRAC_W +: atilt_pkg::RES_W];

        if (cd_side[NCELL].neg)
            pipe_angle = -$signed({1'b0, res});
        else
            pipe_angle = $signed({1'b0, res});
    end

    assign pipe_valid = cd_valid[NCELL];

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_angle_next  = out_angle_reg;
        skid_full_next  = skid_full_reg;
        skid_angle_next = skid_angle_reg;
        if (!out_valid_reg || !out_stall)
        begin
            // drain the skid entry first; the chain is frozen meanwhile
            if (skid_full_reg)
            begin
                out_valid_next = 1'b1;
                out_angle_next = skid_angle_reg;
                skid_full_next = 1'b0;
            end
            else
            begin
                out_valid_next = pipe_valid;
                out_angle_next = pipe_angle;
            end
        end
        else if (pipe_valid && !skid_full_reg)
        begin
            skid_full_next  = 1'b1;
            skid_angle_next = pipe_angle;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            skid_full_reg <= skid_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_angle_reg  <= out_angle_next;
        skid_angle_reg <= skid_angle_next;
    end

    assign in_stall     = skid_full_reg;
    assign out_valid    = out_valid_reg;
    assign angle_tenths = out_angle_reg;

`ifndef SYNTHESIS
    a_skid_behind_output: assert property (@(posedge clk) disable iff (!rst_n)
        skid_full_reg |-> out_valid_reg)
        else $error("skid entry held without a pending output");

    a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_full_reg) |-> $past(out_valid_reg && out_stall))
        else $error("skid entry filled while output was free");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_angle_reg <= 11'sd900 && out_angle_reg >= -11'sd900))
        else $error("tilt angle out of range");
`endif

endmodule
